[sv/punrank_pkg.sv]
// Package for the permutation unranking block.
// Holds field widths, divider sizing, the factorial table and the slot-store command type.
// No dependencies.
`default_nettype none

package punrank_pkg;

    localparam int LEN_W         = 5;
    localparam int RANK_W        = 62;
    localparam int LEN_LIMIT     = 20;
    localparam int WORK_W        = 64;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_CYCLES    = WORK_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(DIV_CYCLES);
    localparam int FACT_DEPTH    = LEN_LIMIT + 1;

    localparam logic [RANK_W-1:0] FACT [FACT_DEPTH] = '{
        62'd1,
        62'd1,
        62'd2,
        62'd6,
        62'd24,
        62'd120,
        62'd720,
        62'd5040,
        62'd40320,
        62'd362880,
        62'd3628800,
        62'd39916800,
        62'd479001600,
        62'd6227020800,
        62'd87178291200,
        62'd1307674368000,
        62'd20922789888000,
        62'd355687428096000,
        62'd6402373705728000,
        62'd121645100408832000,
        62'd2432902008176640000
    };

    typedef struct packed {
        logic             init;
        logic             place;
        logic [LEN_W-1:0] fill;
        logic [LEN_W-1:0] digit;
        logic [LEN_W-1:0] value;
    } t_slot_cmd;

endpackage

`default_nettype wire

[sv/punrank_div.sv]
// Iterative restoring divider of a 64-bit word by a small radix, four quotient bits a cycle.
// Depends on punrank_pkg.
`default_nettype none

module punrank_div
    import punrank_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORK_W-1:0] i_dividend,
    input  wire logic [LEN_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [WORK_W-1:0]      o_quotient,
    output logic [LEN_W-1:0]       o_remainder
);

    logic [WORK_W-1:0] r_work;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORK_W-1:0] n_work;
    logic [LEN_W-1:0]  n_rem;

    always_comb begin
        logic [LEN_W:0] trial;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            trial  = {n_rem, n_work[WORK_W-1]};
            n_work = {n_work[WORK_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem     = LEN_W'(trial - {1'b0, r_div});
                n_work[0] = 1'b1;
            end else begin
                n_rem = trial[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_work <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

[sv/punrank_slots.sv]
// Slot store: an ordered list of free slots and the value assigned to each slot.
// Depends on punrank_pkg.
`default_nettype none

module punrank_slots
    import punrank_pkg::*;
#(
    parameter int MAX_LEN = 20
) (
    input  wire logic                       i_clk,
    input  wire t_slot_cmd                  i_cmd,
    input  wire logic [$clog2(MAX_LEN)-1:0] i_rd_pos,
    output logic [LEN_W-1:0]                o_rd_elem
);

    localparam int IW = $clog2(MAX_LEN);

    logic [LEN_W-1:0] r_free [MAX_LEN];
    logic [LEN_W-1:0] r_slot [MAX_LEN];
    logic [IW-1:0]    sel_slot;

    assign sel_slot = r_free[i_cmd.digit[IW-1:0]][IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int j = 0; j < MAX_LEN; j++) begin
                r_free[j] <= LEN_W'(j);
                r_slot[j] <= i_cmd.fill;
            end
        end else if (i_cmd.place) begin
            r_slot[sel_slot] <= i_cmd.value;
            for (int j = 0; j < MAX_LEN - 1; j++) begin
                if (LEN_W'(j) >= i_cmd.digit) begin
                    r_free[j] <= r_free[j+1];
                end
            end
        end
    end

    assign o_rd_elem = r_slot[i_rd_pos];

endmodule

`default_nettype wire

[sv/permutation_unrank.sv]
// Permutation unranking: turns a rank into a permutation of 0..n-1, one element per result.
// Depends on punrank_pkg, punrank_div and punrank_slots.
//
// Usage:
// The length n is written through i_cfg_we / i_cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. Zero acts as one and values
// above MAX_LEN act as MAX_LEN. Reset sets it to 8 and empties the block. A request on the
// rank channel (i_rank_valid / o_rank_ready) is taken only while idle. The check state
// compares the rank against n factorial; a rank out of range yields one result with
// range_error and last set, and a length of one yields a single result. Otherwise the rank
// is divided by n, n-1 and so on down to 2 in a shared divider that produces four quotient
// bits a cycle; each remainder places one value in the free-slot list. The n results then
// leave in position order, one per cycle while the receiver takes them, through an output
// register on the result channel (o_res_valid / i_res_ready). When the receiver stalls,
// the output register holds and the block waits; a new rank request is accepted while the
// final result still waits in that register.
`default_nettype none

module permutation_unrank
    import punrank_pkg::*;
#(
    parameter int MAX_LEN = 20
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_data,
    input  wire logic              i_rank_valid,
    output logic                   o_rank_ready,
    input  wire logic [RANK_W-1:0] i_rank,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output logic [LEN_W-1:0]       o_position,
    output logic [LEN_W-1:0]       o_element,
    output logic                   o_last,
    output logic                   o_range_error
);

    localparam int IW = $clog2(MAX_LEN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_n;
    logic [RANK_W-1:0] r_rank;
    logic [LEN_W-1:0]  r_v;
    logic [LEN_W-1:0]  r_pos;
    logic              r_o_valid;
    logic [LEN_W-1:0]  r_o_position;
    logic [LEN_W-1:0]  r_o_element;
    logic              r_o_last;
    logic              r_o_error;

    logic [LEN_W-1:0]  eff_len;
    logic              range_err;
    logic              load_ok;
    logic              out_load;
    logic              div_start;
    logic [WORK_W-1:0] div_dividend;
    logic [LEN_W-1:0]  div_divisor;
    logic              div_done;
    logic [WORK_W-1:0] div_quot;
    logic [LEN_W-1:0]  div_rem;
    t_slot_cmd         slot_cmd;
    logic [LEN_W-1:0]  rd_elem;

    always_comb begin
        priority if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_LEN)) begin
            eff_len = LEN_W'(MAX_LEN);
        end else begin
            eff_len = r_len;
        end
    end

    assign range_err    = (r_rank >= FACT[r_n]);
    assign load_ok      = !r_o_valid || i_res_ready;
    assign out_load     = load_ok &&
                          ((r_state == S_CHECK && (range_err || r_n == LEN_W'(1))) ||
                           (r_state == S_EMIT));
    assign o_rank_ready = (r_state == S_IDLE);

    always_comb begin
        div_start      = 1'b0;
        div_divisor    = r_n;
        div_dividend   = WORK_W'(r_rank);
        slot_cmd       = '0;
        slot_cmd.fill  = r_n - LEN_W'(1);
        slot_cmd.digit = div_rem;
        slot_cmd.value = r_v;
        unique case (r_state)
            S_IDLE: begin
            end
            S_CHECK: begin
                if (!range_err && r_n != LEN_W'(1)) begin
                    div_start     = 1'b1;
                    slot_cmd.init = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    slot_cmd.place = 1'b1;
                    if (r_v != r_n - LEN_W'(2)) begin
                        div_start    = 1'b1;
                        div_divisor  = r_n - r_v - LEN_W'(1);
                        div_dividend = div_quot;
                    end
                end
            end
            S_EMIT: begin
            end
        endcase
    end

    punrank_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    punrank_slots #(
        .MAX_LEN (MAX_LEN)
    ) u_slots (
        .i_clk     (i_clk),
        .i_cmd     (slot_cmd),
        .i_rd_pos  (r_pos[IW-1:0]),
        .o_rd_elem (rd_elem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(8);
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_res_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_rank_valid) begin
                        r_rank  <= i_rank;
                        r_n     <= eff_len;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (range_err || r_n == LEN_W'(1)) begin
                        if (load_ok) begin
                            r_o_position <= '0;
                            r_o_element  <= '0;
                            r_o_last     <= 1'b1;
                            r_o_error    <= range_err;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_v     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_v <= r_v + LEN_W'(1);
                        if (r_v == r_n - LEN_W'(2)) begin
                            r_pos   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (load_ok) begin
                        r_o_position <= r_pos;
                        r_o_element  <= rd_elem;
                        r_o_last     <= (r_pos == r_n - LEN_W'(1));
                        r_o_error    <= 1'b0;
                        r_pos        <= r_pos + LEN_W'(1);
                        if (r_pos == r_n - LEN_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    assign o_res_valid   = r_o_valid;
    assign o_position    = r_o_position;
    assign o_element     = r_o_element;
    assign o_last        = r_o_last;
    assign o_range_error = r_o_error;

    // An error result is always the only and final result of its request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_range_error) |-> (o_last && o_element == '0 && o_position == '0))
        else $error("range error result is not a lone final result");

    // The divider reports completion only while the sequencer waits on it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider completed outside the division phase");

    // An accepted request is followed by the range check.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rank_valid && o_rank_ready) |=> (r_state == S_CHECK && !o_rank_ready))
        else $error("accepted request did not enter the range check");

endmodule

`default_nettype wire
